// ===== sv/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

  // field widths
  localparam int unsigned OccW   = 17;
  localparam int unsigned ChW    = 12;
  localparam int unsigned TrimW  = 8;
  localparam int unsigned BoundW = 9;

  // occupancy is a fraction of 65536
  localparam logic [OccW-1:0]   FullOcc   = 17'd65536;
  localparam logic [OccW-1:0]   HalfOcc   = 17'd32768;
  localparam logic [BoundW-1:0] MinLevels = 9'd2;
  localparam logic [BoundW-1:0] MaxLevels = 9'd256;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = QPtrW + 1;

  // config register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgTarget   = 2'd0,
    CfgStepMode = 2'd1,
    CfgLevels   = 2'd2
  } pts_cfg_idx_e;

  // item opcodes
  typedef enum logic {
    OpLoad    = 1'b0,
    OpMeasure = 1'b1
  } pts_op_e;

  // back end sequencer
  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } pts_state_e;

  // effective configuration (already saturated / clamped)
  typedef struct packed {
    logic [OccW-1:0]   target;
    logic              step_mode;
    logic [BoundW-1:0] levels;
  } pts_cfg_t;

  // classified item as queued by the front end
  typedef struct packed {
    logic             is_load;
    logic             in_range;
    logic             enabled;
    logic [ChW-1:0]   channel;
    logic [TrimW-1:0] start_trim;
    logic [OccW-1:0]  occ;
  } pts_item_t;

  // per-channel search state
  typedef struct packed {
    logic [BoundW-1:0] lo;
    logic [BoundW-1:0] hi;
    logic [TrimW-1:0]  trial;
    logic [TrimW-1:0]  best;
    logic [OccW-1:0]   best_occ;
  } pts_entry_t;

  function automatic logic [OccW-1:0] sat_occ(input logic [OccW-1:0] v);
    return (v > FullOcc) ? FullOcc : v;
  endfunction

  function automatic logic [OccW-1:0] abs_diff(input logic [OccW-1:0] a,
                                               input logic [OccW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== sv/pixel_trim_successive_approx.sv =====
// Path: a beat is held in the input queue, then the item and output registers.
// Throughput: one item per cycle while the output side takes results; each
// item reads the per-channel state memory once and writes it at most once;
// same-channel back to back items are served by a write-to-read forward path.
// Reset: control state and configuration return to defaults (target one half,
// midpoint search, 32 levels); per-channel state is undefined until loaded.
`default_nettype none

module pixel_trim_successive_approx import pts_pkg::*; #(
  parameter int unsigned CHANNELS = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [OccW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [ChW-1:0]     channel_i,
  input  wire logic [TrimW-1:0]   start_trim_i,
  input  wire logic [OccW-1:0]    occupancy_i,
  input  wire logic               enabled_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ChW-1:0]          out_channel_o,
  output logic [TrimW-1:0]        next_trim_o,
  output logic [TrimW-1:0]        best_trim_o
);

  pts_cfg_t          cfg_q;
  pts_item_t         head;
  logic              head_valid;
  logic              pop;
  logic [BoundW-1:0] lvl_raw;
  logic [BoundW-1:0] lvl_clamped;

  assign cfg_ready_o = 1'b1;

  // clamp the level count into its legal range
  always_comb begin
    lvl_raw     = cfg_data_i[BoundW-1:0];
    lvl_clamped = lvl_raw;
    if (lvl_raw < MinLevels) lvl_clamped = MinLevels;
    if (lvl_raw > MaxLevels) lvl_clamped = MaxLevels;
  end

  // configuration registers, kept in saturated form
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= HalfOcc;
      cfg_q.step_mode <= 1'b0;
      cfg_q.levels    <= 9'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgTarget:   cfg_q.target    <= sat_occ(cfg_data_i);
        CfgStepMode: cfg_q.step_mode <= cfg_data_i[0];
        CfgLevels:   cfg_q.levels    <= lvl_clamped;
        default: ;
      endcase
    end
  end

  pts_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .channel_i    (channel_i),
    .start_trim_i (start_trim_i),
    .occupancy_i  (occupancy_i),
    .enabled_i    (enabled_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  pts_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .next_trim_o   (next_trim_o),
    .best_trim_o   (best_trim_o)
  );

endmodule

`default_nettype wire

// ===== sv/pts_front.sv =====
`default_nettype none

module pts_front import pts_pkg::*; #(
  parameter int unsigned CHANNELS = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic [ChW-1:0]   channel_i,
  input  wire logic [TrimW-1:0] start_trim_i,
  input  wire logic [OccW-1:0]  occupancy_i,
  input  wire logic             enabled_i,
  output logic                  head_valid_o,
  output pts_item_t             head_o,
  input  wire logic             pop_i
);

  pts_item_t        item_q [QDepth];
  pts_item_t        item_new;
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             full;
  logic             push;

  // classify the incoming beat
  always_comb begin
    item_new.is_load    = (op_i == OpLoad);
    item_new.in_range   = (32'(channel_i) < CHANNELS);
    item_new.enabled    = enabled_i;
    item_new.channel    = channel_i;
    item_new.start_trim = start_trim_i;
    item_new.occ        = sat_occ(occupancy_i);
  end

  assign full       = (count_q == QCntW'(QDepth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = push  ? (wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? (rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= item_new;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_o       = item_q[rd_ptr_q];

  // fill count stays within depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count overflow");

  // a pop only ever takes a stored beat
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

  // a beat accepted into an empty queue is visible next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !head_valid_o) |=> head_valid_o)
    else $error("pushed beat not visible");

endmodule

`default_nettype wire

// ===== sv/pts_back.sv =====
`default_nettype none

module pts_back import pts_pkg::*; #(
  parameter int unsigned CHANNELS = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pts_cfg_t          cfg_i,
  input  wire logic              head_valid_i,
  input  wire pts_item_t         head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ChW-1:0]         out_channel_o,
  output logic [TrimW-1:0]       next_trim_o,
  output logic [TrimW-1:0]       best_trim_o
);

  localparam int unsigned AddrW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ChExtW  = ChW + AddrW;

  pts_state_e        state_q, state_d;
  pts_item_t         item_q;
  pts_entry_t        mem_q [CHANNELS];
  pts_entry_t        rdata_q;
  pts_entry_t        wdata;
  logic [ChExtW-1:0] rd_ext, wr_ext;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic              adv, out_load, mem_we;

  logic              out_valid_q;
  logic [ChW-1:0]    out_channel_q;
  logic [TrimW-1:0]  out_next_q, out_best_q;
  logic [TrimW-1:0]  res_next, res_best;

  logic              below, better;
  logic [BoundW-1:0] lo_n, hi_n;
  logic [BoundW:0]   mid_sum;
  logic [BoundW-1:0] step_up, lvl_top;
  logic [TrimW-1:0]  trial_n;

  // channel to memory address
  assign rd_ext  = ChExtW'(head_i.channel);
  assign wr_ext  = ChExtW'(item_q.channel);
  assign rd_addr = rd_ext[AddrW-1:0];
  assign wr_addr = wr_ext[AddrW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (head_valid_i) state_d = StExec;
      end
      StExec: begin
        if (adv && !head_valid_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    adv      = 1'b0;
    pop_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        pop_o = head_valid_i;
      end
      StExec: begin
        adv   = !out_valid_q || !out_stall_i;
        pop_o = adv && head_valid_i;
      end
      default: begin
        adv   = 1'b0;
        pop_o = 1'b0;
      end
    endcase
    out_load = adv;
    mem_we   = adv && item_q.in_range && (item_q.is_load || item_q.enabled);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // search update for a measurement
  always_comb begin
    below   = (item_q.occ < cfg_i.target);
    better  = abs_diff(item_q.occ, cfg_i.target) <=
              abs_diff(rdata_q.best_occ, cfg_i.target);
    lo_n    = below ? BoundW'(rdata_q.trial) : rdata_q.lo;
    hi_n    = below ? rdata_q.hi : BoundW'(rdata_q.trial);
    mid_sum = (BoundW+1)'(lo_n) + (BoundW+1)'(hi_n);
    lvl_top = cfg_i.levels - 1'b1;
    step_up = BoundW'(rdata_q.trial) + 1'b1;
    if (!cfg_i.step_mode) begin
      trial_n = mid_sum[TrimW:1];
    end else if (below) begin
      trial_n = (step_up > lvl_top) ? lvl_top[TrimW-1:0] : step_up[TrimW-1:0];
    end else begin
      trial_n = (rdata_q.trial == '0) ? '0 : (rdata_q.trial - 1'b1);
    end
  end

  // new entry and result
  always_comb begin
    if (item_q.is_load) begin
      wdata.lo       = '0;
      wdata.hi       = cfg_i.levels;
      wdata.trial    = item_q.start_trim;
      wdata.best     = item_q.start_trim;
      wdata.best_occ = (cfg_i.target < HalfOcc) ? FullOcc : '0;
    end else if (item_q.enabled) begin
      wdata.lo       = lo_n;
      wdata.hi       = hi_n;
      wdata.trial    = trial_n;
      wdata.best     = better ? rdata_q.trial : rdata_q.best;
      wdata.best_occ = better ? item_q.occ : rdata_q.best_occ;
    end else begin
      wdata = rdata_q;
    end
    res_next = item_q.in_range ? wdata.trial : '0;
    res_best = item_q.in_range ? wdata.best  : '0;
  end

  // state memory, read forwarded from a same-cycle write
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q  <= head_i;
      rdata_q <= (mem_we && (wr_addr == rd_addr)) ? wdata : mem_q[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_channel_q <= item_q.channel;
      out_next_q    <= res_next;
      out_best_q    <= res_best;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign next_trim_o   = out_next_q;
  assign best_trim_o   = out_best_q;

  // result is only loaded into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");

  // a load reports its start code as both trial and best
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.is_load && item_q.in_range) |=>
      (out_next_q == out_best_q))
    else $error("load result mismatch");

  // an ignored channel reports zero codes and writes nothing
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !item_q.in_range) |=>
      ((out_next_q == '0) && (out_best_q == '0)))
    else $error("out of range result not zero");

  // memory writes only happen while executing an item
  a_we_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StExec))
    else $error("memory write outside execute");

endmodule

`default_nettype wire

// ===== tb/pixel_trim_successive_approx_tb.sv =====
`timescale 1ns / 1ps

module pixel_trim_successive_approx_tb;
  import pts_pkg::*;

  localparam int unsigned NumChannels = 4096;
  localparam int unsigned OccMax      = (1 << OccW) - 1;
  localparam int unsigned SettleCyc   = 4;
  localparam int unsigned DrainCyc    = 10;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned PoolSize    = 4;
  // index with no register behind it, writes must be dropped
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  typedef enum {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct {
    pts_op_e          op;
    logic [ChW-1:0]   channel;
    logic [TrimW-1:0] start_trim;
    logic [OccW-1:0]  occupancy;
    logic             enabled;
    bit               hold;  // wait for all results before sending
  } pixel_item_t;

  typedef struct {
    logic [ChW-1:0]   channel;
    logic [TrimW-1:0] next_code;
    logic [TrimW-1:0] best_code;
  } trim_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [OccW-1:0]    cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               op_i          = 1'b0;
  logic [ChW-1:0]     channel_i     = '0;
  logic [TrimW-1:0]   start_trim_i  = '0;
  logic [OccW-1:0]    occupancy_i   = '0;
  logic               enabled_i     = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [ChW-1:0]     out_channel_o;
  logic [TrimW-1:0]   next_trim_o;
  logic [TrimW-1:0]   best_trim_o;

  pixel_trim_successive_approx #(
    .CHANNELS(NumChannels)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .channel_i    (channel_i),
    .start_trim_i (start_trim_i),
    .occupancy_i  (occupancy_i),
    .enabled_i    (enabled_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_channel_o(out_channel_o),
    .next_trim_o  (next_trim_o),
    .best_trim_o  (best_trim_o)
  );

  // shadow configuration, updated on each accepted register beat
  logic [OccW-1:0]   tgt_reg    = HalfOcc;
  logic              step_reg   = 1'b0;
  logic [BoundW-1:0] levels_reg = 9'd32;

  // shadow per-channel search state
  pts_entry_t trim_state [NumChannels];

  pixel_item_t  item_q[$];
  trim_result_t trim_expect_q[$];

  idle_mode_e  idle_mode   = IdleNone;
  bit          hold_next   = 1'b0;
  bit          primed [NumChannels];
  int unsigned pool [PoolSize];
  int unsigned left [PoolSize];
  logic        in_taken    = 1'b0;
  int unsigned stuck_cyc   = 0;
  int unsigned fail_count  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_target();
    return (tgt_reg > FullOcc) ? FullOcc : tgt_reg;
  endfunction

  function automatic int unsigned eff_levels();
    if (levels_reg < MinLevels) return MinLevels;
    if (levels_reg > MaxLevels) return MaxLevels;
    return levels_reg;
  endfunction

  // one search step for the item's channel; returns the codes it reports
  function automatic trim_result_t advance_search(input pixel_item_t it);
    trim_result_t res;
    pts_entry_t   e;
    int unsigned  occ;
    int unsigned  tgt;
    int unsigned  lv;
    int unsigned  trial;
    int unsigned  d_new;
    int unsigned  d_best;
    bit           below;
    tgt = eff_target();
    lv  = eff_levels();
    occ = (it.occupancy > FullOcc) ? FullOcc : it.occupancy;
    res.channel   = it.channel;
    res.next_code = '0;
    res.best_code = '0;
    if (it.channel >= NumChannels) return res;
    e = trim_state[it.channel];
    if (it.op == OpLoad) begin
      e.trial    = it.start_trim;
      e.best     = it.start_trim;
      e.lo       = '0;
      e.hi       = BoundW'(lv);
      e.best_occ = (tgt < HalfOcc) ? FullOcc : '0;
    end else if (it.enabled) begin
      trial  = e.trial;
      below  = occ < tgt;
      d_new  = (occ >= tgt) ? occ - tgt : tgt - occ;
      d_best = (e.best_occ >= tgt) ? e.best_occ - tgt : tgt - e.best_occ;
      // ties go to the newer reading
      if (d_new <= d_best) begin
        e.best_occ = OccW'(occ);
        e.best     = e.trial;
      end
      if (below) e.lo = BoundW'(trial);
      else e.hi = BoundW'(trial);
      if (!step_reg) begin
        trial = (int'(e.lo) + int'(e.hi)) >> 1;
      end else if (below) begin
        trial = (trial + 1 > lv - 1) ? lv - 1 : trial + 1;
      end else begin
        trial = (trial == 0) ? 0 : trial - 1;
      end
      e.trial = TrimW'(trial);
    end
    trim_state[it.channel] = e;
    res.next_code = e.trial;
    res.best_code = e.best;
    return res;
  endfunction

  function automatic bit sender_go();
    case (idle_mode)
      IdleSender: return $urandom_range(99) >= 75;
      IdleBoth:   return $urandom_range(99) >= 25;
      default:    return 1'b1;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IdleReceiver: return $urandom_range(99) < 75;
      IdleBoth:     return $urandom_range(99) < 25;
      default:      return 1'b0;
    endcase
  endfunction

  task automatic note_failure(input string what, input int unsigned exp_v,
                              input int unsigned act_v);
    fail_count++;
    if (fail_count <= ReportMax) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  // driver: new beat at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    pixel_item_t item;
    logic        vld;
    vld = in_valid_i && !in_taken;
    if (rst_ni && !vld && item_q.size() != 0 && sender_go()) begin
      if (!item_q[0].hold || trim_expect_q.size() == 0) begin
        item = item_q.pop_front();
        vld  = 1'b1;
        op_i         <= item.op;
        channel_i    <= item.channel;
        start_trim_i <= item.start_trim;
        occupancy_i  <= item.occupancy;
        enabled_i    <= item.enabled;
      end
    end
    in_valid_i  <= vld;
    out_stall_i <= rst_ni && receiver_stall();
  end

  // monitor: check results, predict on accepted beats, watch for hangs
  always @(posedge clk_i) begin
    pixel_item_t  cur;
    trim_result_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (trim_expect_q.size() == 0) begin
          note_failure("unexpected result on channel", 0, out_channel_o);
        end else begin
          want = trim_expect_q.pop_front();
          if (out_channel_o !== want.channel) begin
            note_failure("out_channel", want.channel, out_channel_o);
          end
          if (next_trim_o !== want.next_code) begin
            note_failure("next_trim", want.next_code, next_trim_o);
          end
          if (best_trim_o !== want.best_code) begin
            note_failure("best_trim", want.best_code, best_trim_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved          = 1'b1;
        cur.op         = pts_op_e'(op_i);
        cur.channel    = channel_i;
        cur.start_trim = start_trim_i;
        cur.occupancy  = occupancy_i;
        cur.enabled    = enabled_i;
        cur.hold       = 1'b0;
        trim_expect_q.insert(trim_expect_q.size(), advance_search(cur));
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    stuck_cyc = moved ? 0 : stuck_cyc + 1;
    if (stuck_cyc == StallLimit) begin
      $display("pixel_trim_successive_approx regression: fail");
      $finish;
    end
  end

  task automatic push_item(input pts_op_e op, input int unsigned ch,
                           input int unsigned start, input int unsigned occ,
                           input bit en);
    pixel_item_t it;
    it.op         = op;
    it.channel    = ChW'(ch);
    it.start_trim = TrimW'(start);
    it.occupancy  = OccW'(occ);
    it.enabled    = en;
    it.hold       = hold_next;
    hold_next     = 1'b0;
    if (op == OpLoad) primed[ch] = 1'b1;
    item_q.insert(item_q.size(), it);
  endtask

  // readings clustered around the target, plus the rails and beyond full scale
  function automatic int unsigned pick_occupancy();
    int          v;
    int          span;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      case ($urandom_range(2))
        0:       span = 64;
        1:       span = 2048;
        default: span = 16384;
      endcase
      v = int'(eff_target()) + int'($urandom_range(2 * span)) - span;
      if (v < 0) v = 0;
      if (v > int'(OccMax)) v = OccMax;
      return v;
    end
    if (r < 55) return eff_target();
    if (r < 65) return 0;
    if (r < 75) return FullOcc;
    if (r < 85) return $urandom_range(OccMax, FullOcc + 1);
    return $urandom_range(FullOcc);
  endfunction

  function automatic int unsigned pick_start();
    if ($urandom_range(99) < 85) return $urandom_range(eff_levels() - 1);
    return $urandom_range((1 << TrimW) - 1);
  endfunction

  // corners: rails, saturation, masked pixels, start beyond the level count
  task automatic queue_directed();
    int unsigned top;
    top = (1 << TrimW) - 1;
    push_item(OpLoad, 0, 0, 0, 1'b1);
    push_item(OpLoad, NumChannels - 1, top, OccMax, 1'b0);
    push_item(OpLoad, 7, eff_levels() - 1, 0, 1'b1);
    push_item(OpMeasure, 0, top, 0, 1'b1);
    push_item(OpMeasure, 0, 0, 0, 1'b1);
    push_item(OpMeasure, 0, 0, OccMax, 1'b1);
    push_item(OpMeasure, 0, 0, eff_target(), 1'b1);
    push_item(OpMeasure, NumChannels - 1, 0, 0, 1'b0);
    push_item(OpMeasure, NumChannels - 1, 0, 0, 1'b1);
    push_item(OpMeasure, 7, 0, 0, 1'b1);
    push_item(OpLoad, 7, 0, 0, 1'b1);
    push_item(OpMeasure, 7, 0, FullOcc, 1'b1);
    push_item(OpMeasure, 7, 0, FullOcc, 1'b1);
  endtask

  // interleaved searches on a few channels, with stray and broken traffic
  task automatic queue_search_traffic(input int unsigned count);
    int unsigned slot;
    int unsigned r;
    int unsigned ch;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) hold_next = 1'b1;
      r    = $urandom_range(99);
      slot = $urandom_range(PoolSize - 1);
      ch   = pool[slot];
      if (r < 6) begin
        ch = $urandom_range(NumChannels - 1);
        if (primed[ch] && $urandom_range(1)) begin
          push_item(OpMeasure, ch, $urandom, pick_occupancy(), $urandom_range(1));
        end else begin
          push_item(OpLoad, ch, $urandom, $urandom, $urandom_range(1));
        end
      end else if (r < 12 && primed[ch]) begin
        push_item(OpMeasure, ch, $urandom, pick_occupancy(), 1'b0);
      end else if (r < 16 || !primed[ch] || left[slot] == 0) begin
        if (left[slot] == 0 && $urandom_range(1)) begin
          ch         = $urandom_range(NumChannels - 1);
          pool[slot] = ch;
        end
        push_item(OpLoad, ch, pick_start(), $urandom, $urandom_range(3) != 0);
        left[slot] = $urandom_range(9, 3);
      end else begin
        push_item(OpMeasure, ch, $urandom, pick_occupancy(), 1'b1);
        left[slot]--;
      end
    end
  endtask

  // caller sits just after a falling edge; valid is left high
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= OccW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTarget:   tgt_reg    = OccW'(data);
      CfgStepMode: step_reg   = data[0];
      CfgLevels:   levels_reg = BoundW'(data);
      default:     ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned target, input int unsigned mode,
                            input int unsigned levels);
    write_reg(CfgTarget, target);
    write_reg(CfgStepMode, mode);
    write_reg(CfgLevels, levels);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (item_q.size() != 0 || in_valid_i || trim_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic run_phase(input idle_mode_e mode, input int unsigned count,
                           input bit directed);
    idle_mode = mode;
    if (directed) queue_directed();
    queue_search_traffic(count);
    settle();
  endtask

  initial begin
    for (int unsigned i = 0; i < PoolSize; i++) begin
      pool[i] = $urandom_range(NumChannels - 1);
      left[i] = 0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: midpoint search, 32 levels, target one half
    run_phase(IdleNone, 0, 1'b1);
    // target above full scale, single step, level count clamped up to 2
    set_config(OccMax, 1, 0);
    run_phase(IdleNone, 205, 1'b1);
    set_config(0, 0, MaxLevels);
    run_phase(IdleSender, 205, 1'b0);
    // mode data with junk above bit 0, level count clamped down
    set_config(12345, OccMax, (1 << BoundW) - 1);
    run_phase(IdleReceiver, 205, 1'b0);
    write_reg(CfgNoReg, $urandom);
    set_config(50000, 0, 1);
    run_phase(IdleBoth, 205, 1'b0);
    set_config($urandom_range(FullOcc), $urandom, $urandom_range(MaxLevels, MinLevels));
    run_phase(IdleNone, 205, 1'b0);
    set_config(FullOcc, 1, 300);
    run_phase(IdleSender, 205, 1'b0);
    set_config($urandom, $urandom, $urandom);
    run_phase(IdleReceiver, 205, 1'b0);
    set_config(HalfOcc - 1, 0, 255);
    run_phase(IdleBoth, 205, 1'b0);

    repeat (DrainCyc) @(negedge clk_i);
    if (fail_count == 0 && trim_expect_q.size() == 0) begin
      $display("pixel_trim_successive_approx regression: pass");
    end else begin
      $display("pixel_trim_successive_approx regression: fail");
    end
    $finish;
  end

endmodule
